// ===== hdl/lzwd_pkg.sv =====
package lzwd_pkg;

	// History window geometry
	localparam int unsigned WINDOW_SIZE = 8192;
	localparam int unsigned WIN_AW      = $clog2(WINDOW_SIZE);

	// Match header layout: distance in the low bits, length code above it
	localparam int unsigned DIST_W   = 12;
	localparam int unsigned LEN_W    = 4;
	localparam int unsigned LEN_BIAS = 2;
	localparam int unsigned MAX_RUN  = (1 << LEN_W) - 1 + LEN_BIAS;
	localparam int unsigned REM_W    = $clog2(MAX_RUN + 1);

	// Token group
	localparam int unsigned TOKENS_PER_FLAG = 8;
	localparam int unsigned TOK_W           = 4;

	localparam int unsigned CNT_W = 32;

	// Register map (word index)
	localparam logic REG_OUTPUT_LENGTH = 1'b0;

	typedef enum logic [1:0] {
		PH_FLAG  = 2'd0,
		PH_TOKEN = 2'd1,
		PH_HDR   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		TK_FLAG,
		TK_LIT,
		TK_HDR_LO,
		TK_HDR_HI
	} tok_kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LIT,
		ST_RD,
		ST_WR
	} ctl_state_t;

	typedef struct packed {
		logic clr_wr;
		logic take;
		logic produce;
		logic src_lit;
		logic rd;
		logic next_tok;
	} dp_cmd_t;

	typedef struct packed {
		logic      clr_last;
		tok_kind_t kind;
		logic      prod_ok;
		logic      last_copy;
	} dp_status_t;

endpackage

// ===== hdl/lzwd_datapath.sv =====
module lzwd_datapath import lzwd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_status_t       status,
	input  logic [7:0]       in_byte,
	input  logic [CNT_W-1:0] output_length,
	input  logic             out_stall,
	output logic             out_valid,
	output logic [7:0]       out_byte,
	output logic             run_last,
	output logic             stream_done
);

	logic [7:0] win_mem [WINDOW_SIZE];

	phase_t             phase_q;
	logic [7:0]         flag_q;
	logic [TOK_W-1:0]   tok_left_q;
	logic [7:0]         hdr_lo_q;
	logic [CNT_W-1:0]   count_q;
	logic [WIN_AW-1:0]  clr_q;
	logic               out_valid_q;

	logic [7:0]         lit_q;
	logic [DIST_W-1:0]  dist_q;
	logic [REM_W-1:0]   rem_q;
	logic [7:0]         rd_q;
	logic [7:0]         out_byte_q;
	logic               run_last_q;
	logic               stream_done_q;

	tok_kind_t          kind;
	logic [WIN_AW-1:0]  wp;
	logic [WIN_AW-1:0]  src;
	logic               emit;
	logic               out_free;
	logic               done_hit;
	logic               last_copy;
	logic [7:0]         prod_data;
	logic [REM_W-1:0]   len_full;
	logic               wr_en;
	logic [WIN_AW-1:0]  wr_addr;
	logic [7:0]         wr_data;

	always_comb begin
		unique case (phase_q)
			PH_TOKEN: kind = flag_q[0] ? TK_HDR_LO : TK_LIT;
			PH_HDR:   kind = TK_HDR_HI;
			default:  kind = TK_FLAG;
		endcase
	end

	assign wp        = count_q[WIN_AW-1:0];
	assign src       = wp - WIN_AW'(dist_q);
	assign emit      = count_q < output_length;
	assign out_free  = !out_valid_q || !out_stall;
	assign done_hit  = (count_q + CNT_W'(1)) == output_length;
	assign last_copy = rem_q == REM_W'(1);
	assign prod_data = cmd.src_lit ? lit_q : rd_q;
	assign len_full  = REM_W'(in_byte[7:4]) + REM_W'(LEN_BIAS);

	assign status.clr_last  = clr_q == '1;
	assign status.kind      = kind;
	assign status.prod_ok   = !emit || out_free;
	assign status.last_copy = last_copy;

	// one write port shared by the clearing sweep and produced bytes
	assign wr_en   = cmd.clr_wr || cmd.produce;
	assign wr_addr = cmd.clr_wr ? clr_q : wp;
	assign wr_data = cmd.clr_wr ? 8'h00 : prod_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			win_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			rd_q <= win_mem[src];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FLAG;
			flag_q      <= '0;
			tok_left_q  <= '0;
			hdr_lo_q    <= '0;
			count_q     <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				unique case (kind)
					TK_FLAG: begin
						flag_q     <= in_byte;
						tok_left_q <= TOK_W'(TOKENS_PER_FLAG);
						phase_q    <= PH_TOKEN;
					end
					TK_HDR_LO: begin
						hdr_lo_q <= in_byte;
						phase_q  <= PH_HDR;
					end
					default: begin
					end
				endcase
			end else if (cmd.next_tok) begin
				flag_q     <= flag_q >> 1;
				tok_left_q <= tok_left_q - TOK_W'(1);
				phase_q    <= (tok_left_q == TOK_W'(1)) ? PH_FLAG : PH_TOKEN;
			end
			if (cmd.produce && count_q != '1) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + WIN_AW'(1);
			end
			if (cmd.produce && emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && kind == TK_LIT) begin
			lit_q <= in_byte;
		end
		if (cmd.take && kind == TK_HDR_HI) begin
			dist_q <= {in_byte[3:0], hdr_lo_q};
			rem_q  <= len_full;
		end else if (cmd.produce && !cmd.src_lit) begin
			rem_q <= rem_q - REM_W'(1);
		end
		if (cmd.produce && emit) begin
			out_byte_q    <= prod_data;
			run_last_q    <= cmd.src_lit || last_copy || done_hit;
			stream_done_q <= done_hit;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign run_last    = run_last_q;
	assign stream_done = stream_done_q;

	a_no_prod_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.produce && cmd.clr_wr))
		else $error("byte produced during window clear");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && cmd.produce) |-> !emit)
		else $error("pending result overwritten");

	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q >= $past(count_q))
		else $error("produced count went backwards");

	a_copy_len: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.produce && !cmd.src_lit) |-> rem_q != '0)
		else $error("match copy past its length");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && stream_done_q) |-> run_last_q)
		else $error("final stream byte not marked last of its request");

endmodule

// ===== hdl/lzwd_ctrl.sv =====
module lzwd_ctrl import lzwd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  dp_status_t status,
	output logic       in_ready,
	output dp_cmd_t    cmd
);

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (status.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					unique case (status.kind)
						TK_LIT:    state_d = ST_LIT;
						TK_HDR_HI: state_d = ST_RD;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_LIT: begin
				if (status.prod_ok) state_d = ST_IDLE;
			end
			ST_RD: begin
				state_d = ST_WR;
			end
			ST_WR: begin
				if (status.prod_ok) state_d = status.last_copy ? ST_IDLE : ST_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			ST_LIT: begin
				cmd.produce  = status.prod_ok;
				cmd.src_lit  = 1'b1;
				cmd.next_tok = status.prod_ok;
			end
			ST_RD: begin
				cmd.rd = 1'b1;
			end
			ST_WR: begin
				cmd.produce  = status.prod_ok;
				cmd.next_tok = status.prod_ok && status.last_copy;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hdl/lzwd_window_decoder.sv =====
// LZSS decoder with an 8 KiB history window, 12-bit distance and 4-bit length.
// Compressed bytes come in one request at a time on in_byte; decoded bytes
// leave one request at a time on out_byte, with run_last marking the final
// byte caused by one input byte and stream_done marking byte number
// output_length. Bytes past output_length are still decoded into the window
// but are not sent. After reset the window is swept to zero, one entry per
// cycle through all 8192 entries; no input is taken meanwhile (register
// writes are). A flag byte or the low byte of a match header is taken in the
// idle state alone; a literal then passes through a write state, and the high
// byte of a header through a read state and a write state for each copied
// byte (length 2 to 17); a stall on the output side holds either write.
// Each copied byte is a registered read of the single window RAM followed by
// the write of that byte, so a copy whose distance is shorter than its length
// sees the bytes it has just written. A decoded byte sits in an output register,
// so the next input byte is taken while that result waits. Register map (APB,
// 32-bit): 0x0 output_length (R/W, reset 0); only paddr[2] is decoded, so 0x1-0x3
// alias it and 0x4-0x7 read zero and ignore writes. pready is tied high.
module lzss_window_decoder import lzwd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// compressed input
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       in_byte,
	// decoded output
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_byte,
	output logic             run_last,
	output logic             stream_done,
	// configuration
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [CNT_W-1:0] output_length_q;
	logic             in_ready;
	dp_cmd_t          cmd;
	dp_status_t       status;

	// register file: a single word, selected by the word index paddr[2]
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_OUTPUT_LENGTH) ? output_length_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_length_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_OUTPUT_LENGTH) begin
			output_length_q <= pwdata;
		end
	end

	// input is only taken while the sequencer sits idle
	assign in_stall = !in_ready;

	lzwd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	lzwd_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.in_byte       (in_byte),
		.output_length (output_length_q),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.out_byte      (out_byte),
		.run_last      (run_last),
		.stream_done   (stream_done)
	);

endmodule

// ===== test/lzwd_checker.sv =====
module lzwd_checker import lzwd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  out_byte,
	input  logic        run_last,
	input  logic        stream_done,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending,
	output logic [31:0] bytes_decoded
);

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       done;
	} dec_byte_t;

	// shadow decoder state
	logic [7:0]       history [WINDOW_SIZE];
	phase_t           tok_phase;
	logic [7:0]       flags;
	logic [TOK_W-1:0] tok_left;
	logic [7:0]       hdr_lo;
	logic [31:0]      produced;
	logic [31:0]      out_len;

	dec_byte_t decoded_q[$];
	dec_byte_t held;
	logic      have_held;

	// every byte lands in the window; only in-stream bytes become results
	task automatic produce_byte(input logic [7:0] b);
		history[produced[WIN_AW-1:0]] = b;
		if (produced < out_len) begin
			if (have_held)
				decoded_q.push_back(held);
			held.data = b;
			held.last = 1'b0;
			held.done = (produced + 32'd1 == out_len);
			have_held = 1'b1;
		end
		if (produced != '1)
			produced = produced + 32'd1;
	endtask

	task automatic next_token();
		flags    = flags >> 1;
		tok_left = tok_left - 1'b1;
		tok_phase = (tok_left == '0) ? PH_FLAG : PH_TOKEN;
	endtask

	task automatic decode_request(input logic [7:0] b);
		logic [15:0]       hdr;
		logic [WIN_AW-1:0] src;
		int                run;
		have_held = 1'b0;
		case (tok_phase)
			PH_TOKEN: begin
				if (!flags[0]) begin
					produce_byte(b);
					next_token();
				end else begin
					hdr_lo    = b;
					tok_phase = PH_HDR;
				end
			end
			PH_HDR: begin
				hdr = {b, hdr_lo};
				run = int'(hdr[15 -: LEN_W]) + int'(LEN_BIAS);
				// byte by byte, so overlapping copies see fresh bytes
				for (int i = 0; i < run; i++) begin
					src = produced[WIN_AW-1:0] - WIN_AW'(hdr[DIST_W-1:0]);
					produce_byte(history[src]);
				end
				next_token();
			end
			default: begin
				flags     = b;
				tok_left  = TOK_W'(TOKENS_PER_FLAG);
				tok_phase = PH_TOKEN;
			end
		endcase
		if (have_held) begin
			held.last = 1'b1;
			decoded_q.push_back(held);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : scoreboard
		dec_byte_t want;
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_SIZE; i++)
				history[i] = '0;
			tok_phase  = PH_FLAG;
			flags      = '0;
			tok_left   = '0;
			hdr_lo     = '0;
			produced   = '0;
			out_len    = '0;
			have_held  = 1'b0;
			fail_count = 0;
			decoded_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (decoded_q.size() == 0) begin
					$error("out_byte: expected none, actual %02h", out_byte);
					fail_count++;
				end else begin
					want = decoded_q.pop_front();
					if (out_byte !== want.data) begin
						$error("out_byte: expected %02h, actual %02h", want.data, out_byte);
						fail_count++;
					end
					if (run_last !== want.last) begin
						$error("run_last: expected %0b, actual %0b", want.last, run_last);
						fail_count++;
					end
					if (stream_done !== want.done) begin
						$error("stream_done: expected %0b, actual %0b", want.done, stream_done);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				decode_request(in_byte);
			if (psel && penable && pwrite && pready && paddr[2] == REG_OUTPUT_LENGTH)
				out_len = pwdata;
		end
		pending       = decoded_q.size();
		bytes_decoded = produced;
	end

endmodule

// ===== test/lzss_window_decoder_test.sv =====
module lzss_window_decoder_test;
	import lzwd_pkg::*;

	// byte addresses on the config port
	localparam logic [2:0] ADDR_OUTPUT_LENGTH = {REG_OUTPUT_LENGTH, 2'b00};
	localparam logic [2:0] ADDR_SPARE         = {~REG_OUTPUT_LENGTH, 2'b00};
	// quiet wait after the last result, longer than the longest copy
	localparam int SETTLE_CYCLES = 48;
	// clear sweep plus a very slow run, several times over
	localparam int LIMIT_CYCLES = 900000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        run_last;
	logic        stream_done;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int          fail_count;
	int          pending;
	logic [31:0] bytes_decoded;

	// idle odds in percent, per side
	int in_idle_pct = 0;
	int out_stall_pct = 0;

	lzss_window_decoder DUT (.*);

	lzwd_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: fresh stall decision every cycle
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < out_stall_pct);

	// one request on the input side; returns at the accepting edge with
	// valid still high, so a following request can go back to back
	task automatic send_byte(input logic [7:0] b);
		if ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < in_idle_pct);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// match header goes out low byte first
	task automatic send_header(input logic [15:0] hdr);
		send_byte(hdr[7:0]);
		send_byte(hdr[15:8]);
	endtask

	// stop sending, let every pending byte come out, then let any copy
	// that makes no results run out too; the first edge lets the checker
	// count the last accepted request
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// setup + access, then idle so writes never touch back to back
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// well-formed group: flag then eight tokens with random content; cut
	// short when the budget runs out
	task automatic send_random_group(inout int budget);
		logic [7:0]  flag;
		logic [11:0] distance;
		logic [3:0]  code;
		int          pick;
		flag = 8'($urandom);
		send_byte(flag);
		budget--;
		for (int t = 0; t < TOKENS_PER_FLAG && budget > 0; t++) begin
			if (!flag[t]) begin
				send_byte(8'($urandom));
				budget--;
			end else begin
				pick = $urandom_range(9);
				// mostly short distances so copies overlap and repeat
				if (pick < 5)
					distance = 12'($urandom_range(1, 16));
				else if (pick < 8)
					distance = 12'($urandom_range(17, 600));
				else
					distance = 12'($urandom_range(0, 4095));
				code = 4'($urandom);
				send_header({code, distance});
				budget -= 2;
			end
		end
	endtask

	// length = bytes so far + headroom, saturating
	task automatic random_phase(input int idle_pct, input int stall_pct,
			input logic [31:0] headroom, input int items);
		int budget;
		drain();
		if (headroom > 32'hFFFF_FFFF - bytes_decoded)
			apb_write(ADDR_OUTPUT_LENGTH, 32'hFFFF_FFFF);
		else
			apb_write(ADDR_OUTPUT_LENGTH, bytes_decoded + headroom);
		in_idle_pct   = idle_pct;
		out_stall_pct = stall_pct;
		budget = items;
		while (budget > 0) begin
			// a stray byte now and then knocks the token framing off
			if ($urandom_range(9) == 0) begin
				send_byte(8'($urandom));
				budget--;
			end else begin
				send_random_group(budget);
			end
		end
	endtask

	initial begin
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// length still 0 from reset: flag + literal decode silently
		send_byte(8'hFE);
		send_byte(8'h00);
		drain();
		// spare address must not open the stream
		apb_write(ADDR_SPARE, 32'hFFFF_FFFF);
		send_header(16'h3005);
		drain();
		apb_write(ADDR_OUTPUT_LENGTH, 32'hFFFF_FFFF);
		// matches into the reset window, zero distance, longest run,
		// distance one repeat, extremes of both header fields
		send_header(16'h0000);
		send_header(16'hFFFF);
		send_header(16'hF001);
		send_header(16'h0001);
		send_header(16'h1FFF);
		send_header(16'h2003);
		// group of literals with the edge byte values
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h55);
		send_byte(8'hAA);
		send_byte(8'h01);
		send_byte(8'h80);
		send_byte(8'h7F);
		send_byte(8'hFE);

		// length moved mid-stream: end falls inside a copy, rest is past end
		drain();
		apb_write(ADDR_OUTPUT_LENGTH, bytes_decoded + 32'd3);
		send_byte(8'h02);
		send_byte(8'h11);
		send_header(16'h4002);
		send_byte(8'h22);
		drain();
		apb_write(ADDR_OUTPUT_LENGTH, 32'h0000_0000);
		send_byte(8'h33);

		random_phase(0, 0, 32'hFFFF_FFFF, 64);
		random_phase(80, 0, 32'd20000, 64);
		random_phase(0, 80, 32'd20000, 64);
		// stream ends somewhere inside this phase
		random_phase(38, 38, 32'($urandom_range(40, 150)), 64);
		random_phase(0, 0, 32'd20000, 64);

		drain();
		if (fail_count == 0)
			$display("lzss_window_decoder: match");
		else
			$display("lzss_window_decoder: mismatch");
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * 10);
		$display("lzss_window_decoder: mismatch");
		$finish;
	end

endmodule
